[rtl/i2a_pkg.sv]
// Package for the integer to ASCII converter: field widths, mode codes,
// ASCII constants, state encodings and the emitter control struct.
// No dependencies.
package i2a_pkg;

   localparam int ValueWidth  = 64;
   localparam int CharWidth   = 8;
   localparam int ModeWidth   = 2;
   localparam int BcdDigits   = 20;
   localparam int NibbleWidth = 4 * BcdDigits;
   localparam int CountWidth  = 6;   // counts the 64 shift steps
   localparam int DigitCntW   = 5;   // holds up to 20 digits

   localparam logic [ModeWidth-1:0] MODE_UNSIGNED = 2'd0;
   localparam logic [ModeWidth-1:0] MODE_SIGNED   = 2'd1;
   localparam logic [ModeWidth-1:0] MODE_HEX      = 2'd2;
   localparam int                   MODE_HEX_BIT  = 1;

   localparam logic [CharWidth-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [CharWidth-1:0] ASCII_UPPER = 8'h41;
   localparam logic [CharWidth-1:0] ASCII_MINUS = 8'h2d;
   localparam logic [CharWidth-1:0] ASCII_H     = 8'h68;

   typedef enum logic [2:0] {
      T_IDLE = 3'b001,
      T_CONV = 3'b010,
      T_EMIT = 3'b100
   } top_state_type;

   typedef enum logic [5:0] {
      E_IDLE   = 6'b000001,
      E_SKIP   = 6'b000010,
      E_SIGN   = 6'b000100,
      E_DIGIT  = 6'b001000,
      E_SUFFIX = 6'b010000,
      E_DRAIN  = 6'b100000
   } emit_state_type;

   typedef struct packed {
      logic start;
      logic hex;
      logic neg;
   } emit_ctl_type;

   // Maps one digit value to its upper-case ASCII code.
   function automatic logic [CharWidth-1:0] digit_char(input logic [3:0] nib);
      logic [CharWidth-1:0] wide;
      wide = {4'b0, nib};
      if (nib < 4'd10) begin
         digit_char = ASCII_ZERO + wide;
      end else begin
         digit_char = ASCII_UPPER + wide - 8'd10;
      end
   endfunction

endpackage

[rtl/integer_to_ascii_converter.sv]
// Top level of the integer to ASCII converter: input handshake, sign
// handling and sequencing of the BCD converter and character emitter.
// Depends on i2a_pkg, i2a_dabble and i2a_emit.
//
// Usage:
//   The req channel takes one item: req_tdata carries the 64-bit value and
//   req_tuser the mode (0 unsigned decimal, 1 signed decimal, 2 or 3 hex).
//   The rsp channel returns the ASCII text one character per item, most
//   significant first; rsp_tlast marks the final character of the value.
//   Decimal values pass through a one-bit-per-cycle BCD converter; hex
//   values skip it. Leading zero digits are dropped at one digit per
//   cycle (at most 19), then one character leaves per cycle while the
//   receiver is ready. The block works on one item at a time: req_tready
//   is high only while it is idle, and it drops again until the last
//   character is taken. When the receiver stalls, the current character
//   holds in the output register and the emitter waits. Synchronous
//   reset returns the block to idle and discards any pending characters.
module integer_to_ascii_converter
   import i2a_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] value
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] character
   output logic        rsp_tlast
);

   top_state_type          state_ff, state_in;
   logic                   neg_ff, neg_in;
   logic                   accept;
   logic                   is_hex;
   logic                   is_neg;
   logic [ValueWidth-1:0]  magnitude;
   logic                   dab_done;
   logic [NibbleWidth-1:0] dab_bcd;
   emit_ctl_type           ectl;
   logic [NibbleWidth-1:0] enibbles;
   logic                   ebusy;

   assign req_tready = (state_ff == T_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_hex     = req_tuser[MODE_HEX_BIT];
   assign is_neg     = (req_tuser == MODE_SIGNED) && req_tdata[ValueWidth-1];
   assign magnitude  = is_neg ? (ValueWidth'(0) - req_tdata) : req_tdata;

   i2a_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .start (accept && !is_hex),
      .bin   (magnitude),
      .done  (dab_done),
      .bcd   (dab_bcd)
   );

   // Hex values go straight to the emitter as sixteen nibbles.
   always_comb begin
      ectl.start = (accept && is_hex) || (state_ff == T_CONV && dab_done);
      ectl.hex   = accept && is_hex;
      ectl.neg   = (state_ff == T_CONV) && neg_ff;
      enibbles   = accept ? {{(NibbleWidth-ValueWidth){1'b0}}, req_tdata} : dab_bcd;
   end

   i2a_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ectl),
      .nibbles   (enibbles),
      .busy      (ebusy),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               neg_in   = is_neg;
               state_in = is_hex ? T_EMIT : T_CONV;
            end
         end
         T_CONV: begin
            if (dab_done) begin
               state_in = T_EMIT;
            end
         end
         T_EMIT: begin
            if (!ebusy) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
      end else begin
         state_ff <= state_in;
      end
      neg_ff <= neg_in;
   end

`ifndef SYNTH
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("top state is not one-hot");

   a_no_output_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == T_IDLE |-> !rsp_tvalid)
      else $error("character presented while idle");

   a_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      dab_done |-> state_ff == T_CONV)
      else $error("BCD conversion finished outside the convert phase");

   a_hex_to_emit: assert property (@(posedge clock) disable iff (reset)
      accept && is_hex |=> state_ff == T_EMIT && ebusy)
      else $error("hex item did not start the emitter");
`endif

endmodule

[rtl/i2a_dabble.sv]
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on i2a_pkg.
module i2a_dabble
   import i2a_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [ValueWidth-1:0]  bin,
   output logic                   done,
   output logic [NibbleWidth-1:0] bcd
);

   logic [ValueWidth-1:0]  bin_ff, bin_in;
   logic [NibbleWidth-1:0] bcd_ff, bcd_in;
   logic [CountWidth-1:0]  cnt_ff, cnt_in;
   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [NibbleWidth-1:0] adj;

   // Each digit that is five or more gets three added before the shift.
   always_comb begin
      for (int d = 0; d < BcdDigits; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in = bin;
         bcd_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         bcd_in = {adj[NibbleWidth-2:0], bin_ff[ValueWidth-1]};
         bin_in = {bin_ff[ValueWidth-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == {CountWidth{1'b1}}) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

[rtl/i2a_emit.sv]
// Character emitter: skips leading zero digits, then sends sign, digits
// and hex suffix one item at a time through an output register.
// Depends on i2a_pkg.
module i2a_emit
   import i2a_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  emit_ctl_type           ctl,
   input  logic [NibbleWidth-1:0] nibbles,
   output logic                   busy,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [CharWidth-1:0]   out_char,
   output logic                   out_last
);

   emit_state_type         state_ff, state_in;
   logic [NibbleWidth-1:0] nib_ff, nib_in;
   logic [DigitCntW-1:0]   cnt_ff, cnt_in;
   logic                   hex_ff, hex_in;
   logic                   neg_ff, neg_in;
   logic                   valid_ff, valid_in;
   logic [CharWidth-1:0]   char_ff, char_in;
   logic                   last_ff, last_in;
   logic                   slot_free;
   logic [3:0]             top_nib;

   assign slot_free = !valid_ff || out_ready;
   assign top_nib   = nib_ff[NibbleWidth-1 -: 4];

   always_comb begin
      state_in = state_ff;
      nib_in   = nib_ff;
      cnt_in   = cnt_ff;
      hex_in   = hex_ff;
      neg_in   = neg_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !out_ready;
      case (state_ff)
         E_IDLE: begin
            if (ctl.start) begin
               nib_in   = nibbles;
               cnt_in   = DigitCntW'(BcdDigits);
               hex_in   = ctl.hex;
               neg_in   = ctl.neg;
               state_in = E_SKIP;
            end
         end
         E_SKIP: begin
            // At least one digit always remains, so zero prints as one '0'.
            if (top_nib == 4'd0 && cnt_ff != DigitCntW'(1)) begin
               nib_in = {nib_ff[NibbleWidth-5:0], 4'b0};
               cnt_in = cnt_ff - 1'b1;
            end else if (neg_ff) begin
               state_in = E_SIGN;
            end else begin
               state_in = E_DIGIT;
            end
         end
         E_SIGN: begin
            if (slot_free) begin
               valid_in = 1'b1;
               char_in  = ASCII_MINUS;
               last_in  = 1'b0;
               state_in = E_DIGIT;
            end
         end
         E_DIGIT: begin
            if (slot_free) begin
               valid_in = 1'b1;
               char_in  = digit_char(top_nib);
               last_in  = (cnt_ff == DigitCntW'(1)) && !hex_ff;
               nib_in   = {nib_ff[NibbleWidth-5:0], 4'b0};
               cnt_in   = cnt_ff - 1'b1;
               if (cnt_ff == DigitCntW'(1)) begin
                  state_in = hex_ff ? E_SUFFIX : E_DRAIN;
               end
            end
         end
         E_SUFFIX: begin
            if (slot_free) begin
               valid_in = 1'b1;
               char_in  = ASCII_H;
               last_in  = 1'b1;
               state_in = E_DRAIN;
            end
         end
         E_DRAIN: begin
            if (slot_free) begin
               state_in = E_IDLE;
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      nib_ff  <= nib_in;
      cnt_ff  <= cnt_in;
      hex_ff  <= hex_in;
      neg_ff  <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign busy      = (state_ff != E_IDLE);
   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

endmodule
